// ===== sv/hilbert_index_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Hilbert index encoder assertion macros
// Assertion wrappers that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef HILBERT_INDEX_ENCODER_MACROS_SVH
`define HILBERT_INDEX_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property sampled on the clock and disabled during reset.
`define HIE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hie assertion failed");
// Next-cycle implication, disabled during reset.
`define HIE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hie next-cycle assertion failed");
`else
`define HIE_ASSERT(lbl, clk, rstn, prop)
`define HIE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/hie_pkg.sv =====
// ----------------------------------------------------------------------------
// Hilbert index encoder package
// Datapath widths, register indexes, quadrant codes and unit control types.
// ----------------------------------------------------------------------------
package hie_pkg;

  // Q16.16 operand width
  localparam int unsigned VW = 32;
  // Offset point minus centre; the centre drifts up to about 2^34
  localparam int unsigned DW = 36;
  // Exact product and sum of two products
  localparam int unsigned PW = DW + VW;
  localparam int unsigned SW = PW + 1;
  // Level count register width
  localparam int unsigned LCW = 5;
  // Configuration index width
  localparam int unsigned CIW = 3;

  localparam logic [CIW-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CIW-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CIW-1:0] REG_RED_AXIS_X  = 3'd2;
  localparam logic [CIW-1:0] REG_RED_AXIS_Y  = 3'd3;
  localparam logic [CIW-1:0] REG_BLUE_AXIS_X = 3'd4;
  localparam logic [CIW-1:0] REG_BLUE_AXIS_Y = 3'd5;
  localparam logic [CIW-1:0] REG_LEVEL_COUNT = 3'd6;

  localparam logic [1:0] QUAD_LOW_LOW   = 2'd0;
  localparam logic [1:0] QUAD_LOW_HIGH  = 2'd1;
  localparam logic [1:0] QUAD_HIGH_HIGH = 2'd2;
  localparam logic [1:0] QUAD_HIGH_LOW  = 2'd3;

  typedef struct packed {
    logic acc_load;   // move product into accumulator
    logic sign_take;  // capture sign of accumulator plus product
  } mac_ctrl_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } mac_stat_t;

endpackage

// ===== sv/hie_mac.sv =====
// ----------------------------------------------------------------------------
// Hilbert index encoder multiply-accumulate unit
// Shared 36x32 signed multiplier with product register, accumulator and
// registered sign test of a two-term dot product.
// ----------------------------------------------------------------------------
module hie_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [hie_pkg::DW-1:0]     a_i,
  input  logic signed [hie_pkg::VW-1:0]     b_i,
  input  hie_pkg::mac_ctrl_t                ctrl_i,
  output hie_pkg::mac_stat_t                stat_o
);

  logic signed [hie_pkg::PW-1:0] prod_d, prod_q;
  logic signed [hie_pkg::PW-1:0] acc_q;
  logic signed [hie_pkg::SW-1:0] sum;
  hie_pkg::mac_stat_t            stat_q;

  assign prod_d = a_i * b_i;
  assign sum    = {prod_q[hie_pkg::PW-1], prod_q} + {acc_q[hie_pkg::PW-1], acc_q};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_i.acc_load) begin
      acc_q <= prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
    end else if (ctrl_i.sign_take) begin
      stat_q.neg  <= sum[hie_pkg::SW-1];
      stat_q.zero <= (sum == '0);
    end
  end

  assign stat_o = stat_q;

endmodule

// ===== sv/hilbert_index_encoder.sv =====
// ----------------------------------------------------------------------------
// Hilbert index encoder
// Maps a Q16.16 point to its Hilbert curve index inside a configurable box.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  point_x_i, point_y_i
//   out      output     out_valid_o/out_stall_i hilbert_index_o
//   cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// Each level steps through S_RX, S_RY, S_BX, S_BY, S_SB and S_UPD: four products
// through the one 36x32 multiplier, red and blue sign captures, one axis/offset update.
// A point runs L levels, L being the clamped level count; new points wait for S_IDLE.
// Reset is asynchronous, active low, and restores the box registers.
// A stalled output word holds the block in its final state until taken.
// ----------------------------------------------------------------------------
`include "hilbert_index_encoder_macros.svh"

module hilbert_index_encoder #(
  parameter int unsigned MAX_LEVELS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            point_x_i,
  input  logic signed [31:0]            point_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   hilbert_index_o,
  input  logic                          cfg_we_i,
  input  logic [hie_pkg::CIW-1:0]       cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned LW = $clog2(MAX_LEVELS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RX   = 8'b0000_0010,
    S_RY   = 8'b0000_0100,
    S_BX   = 8'b0000_1000,
    S_BY   = 8'b0001_0000,
    S_SB   = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic signed [31:0]            origin_x_q, origin_y_q;
  logic signed [31:0]            red_x_q, red_y_q, blue_x_q, blue_y_q;
  logic [hie_pkg::LCW-1:0]       level_count_q;

  // working registers
  logic signed [hie_pkg::DW-1:0] dx_q, dy_q;
  logic signed [31:0]            rx_q, ry_q, bx_q, by_q;
  logic [31:0]                   idx_q;
  logic [LW-1:0]                 lvl_q, levels_q;
  hie_pkg::mac_stat_t            rsgn_q;
  logic                          out_valid_q;
  logic [31:0]                   out_idx_q;

  logic                          in_take, out_take, out_free, last_lvl;
  logic [hie_pkg::LCW-1:0]       lc_clamped;
  logic signed [hie_pkg::DW-1:0] mac_a;
  logic signed [31:0]            mac_b;
  hie_pkg::mac_ctrl_t            mac_ctrl;
  hie_pkg::mac_stat_t            mac_stat;
  logic signed [31:0]            rxh, ryh, bxh, byh;
  logic signed [hie_pkg::DW-1:0] rxe, rye, bxe, bye;
  logic [1:0]                    quad;
  logic signed [hie_pkg::DW-1:0] dx_n, dy_n;
  logic signed [31:0]            rx_n, ry_n, bx_n, by_n;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_lvl   = (lvl_q == levels_q - LW'(1));

  always_comb begin
    if (level_count_q == '0) begin
      lc_clamped = hie_pkg::LCW'(1);
    end else if (level_count_q > hie_pkg::LCW'(MAX_LEVELS)) begin
      lc_clamped = hie_pkg::LCW'(MAX_LEVELS);
    end else begin
      lc_clamped = level_count_q;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      red_x_q       <= 32'sd65536;
      red_y_q       <= '0;
      blue_x_q      <= '0;
      blue_y_q      <= 32'sd65536;
      level_count_q <= hie_pkg::LCW'(16);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hie_pkg::REG_ORIGIN_X:    origin_x_q    <= cfg_data_i;
        hie_pkg::REG_ORIGIN_Y:    origin_y_q    <= cfg_data_i;
        hie_pkg::REG_RED_AXIS_X:  red_x_q       <= cfg_data_i;
        hie_pkg::REG_RED_AXIS_Y:  red_y_q       <= cfg_data_i;
        hie_pkg::REG_BLUE_AXIS_X: blue_x_q      <= cfg_data_i;
        hie_pkg::REG_BLUE_AXIS_Y: blue_y_q      <= cfg_data_i;
        hie_pkg::REG_LEVEL_COUNT: level_count_q <= cfg_data_i[hie_pkg::LCW-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mac_a    = dx_q;
    mac_b    = rx_q;
    mac_ctrl = '0;
    case (state_q)
      S_RX: begin
        mac_a = dx_q;
        mac_b = rx_q;
      end
      S_RY: begin
        mac_a = dy_q;
        mac_b = ry_q;
        mac_ctrl.acc_load = 1'b1;
      end
      S_BX: begin
        mac_a = dx_q;
        mac_b = bx_q;
        mac_ctrl.sign_take = 1'b1;
      end
      S_BY: begin
        mac_a = dy_q;
        mac_b = by_q;
        mac_ctrl.acc_load = 1'b1;
      end
      S_SB: begin
        mac_ctrl.sign_take = 1'b1;
      end
      default: ;
    endcase
  end

  hie_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .ctrl_i (mac_ctrl),
    .stat_o (mac_stat)
  );

  // level update: halve axes, pick quadrant, move offset, rotate axes
  assign rxh = rx_q >>> 1;
  assign ryh = ry_q >>> 1;
  assign bxh = bx_q >>> 1;
  assign byh = by_q >>> 1;
  assign rxe = hie_pkg::DW'(rxh);
  assign rye = hie_pkg::DW'(ryh);
  assign bxe = hie_pkg::DW'(bxh);
  assign bye = hie_pkg::DW'(byh);

  always_comb begin
    if ((rsgn_q.neg || rsgn_q.zero) && (mac_stat.neg || mac_stat.zero)) begin
      quad = hie_pkg::QUAD_LOW_LOW;
    end else if (rsgn_q.neg || rsgn_q.zero) begin
      quad = hie_pkg::QUAD_LOW_HIGH;
    end else if (!mac_stat.neg) begin
      quad = hie_pkg::QUAD_HIGH_HIGH;
    end else begin
      quad = hie_pkg::QUAD_HIGH_LOW;
    end
  end

  // the offset is point minus centre, so it moves opposite to the centre
  always_comb begin
    dx_n = dx_q;
    dy_n = dy_q;
    rx_n = rxh;
    ry_n = ryh;
    bx_n = bxh;
    by_n = byh;
    case (quad)
      hie_pkg::QUAD_LOW_LOW: begin
        dx_n = dx_q + bxe + rxe;
        dy_n = dy_q + bye + rye;
        rx_n = bxh;
        ry_n = byh;
        bx_n = rxh;
        by_n = ryh;
      end
      hie_pkg::QUAD_LOW_HIGH: begin
        dx_n = dx_q + rxe - bxe;
        dy_n = dy_q + rye - bye;
      end
      hie_pkg::QUAD_HIGH_HIGH: begin
        dx_n = dx_q - bxe - rxe;
        dy_n = dy_q - bye - rye;
      end
      hie_pkg::QUAD_HIGH_LOW: begin
        dx_n = dx_q + bxe - rxe;
        dy_n = dy_q + bye - rye;
        rx_n = -bxh;
        ry_n = -byh;
        bx_n = -rxh;
        by_n = -ryh;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RX;
      S_RX:   state_d = S_RY;
      S_RY:   state_d = S_BX;
      S_BX:   state_d = S_BY;
      S_BY:   state_d = S_SB;
      S_SB:   state_d = S_UPD;
      S_UPD:  state_d = last_lvl ? S_DONE : S_RX;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      levels_q    <= LW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_take) begin
        lvl_q    <= '0;
        levels_q <= LW'(lc_clamped);
      end else if (state_q == S_UPD) begin
        lvl_q <= last_lvl ? lvl_q : lvl_q + LW'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      dx_q  <= hie_pkg::DW'(point_x_i) - hie_pkg::DW'(origin_x_q);
      dy_q  <= hie_pkg::DW'(point_y_i) - hie_pkg::DW'(origin_y_q);
      rx_q  <= red_x_q;
      ry_q  <= red_y_q;
      bx_q  <= blue_x_q;
      by_q  <= blue_y_q;
      idx_q <= '0;
    end else if (state_q == S_UPD) begin
      dx_q  <= dx_n;
      dy_q  <= dy_n;
      rx_q  <= rx_n;
      ry_q  <= ry_n;
      bx_q  <= bx_n;
      by_q  <= by_n;
      idx_q <= {idx_q[29:0], quad};
    end
    // hold the red sign while the blue products run
    if (state_q == S_BY) begin
      rsgn_q <= mac_stat;
    end
    if (state_q == S_DONE && out_free) begin
      out_idx_q <= idx_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hilbert_index_o = out_idx_q;

  `HIE_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_RX)
  `HIE_ASSERT(a_level_in_range, clk_i, rst_ni, (state_q == S_IDLE) || (lvl_q < levels_q))
  `HIE_ASSERT_NEXT(a_last_level_done, clk_i, rst_ni, (state_q == S_UPD) && last_lvl, state_q == S_DONE)
  `HIE_ASSERT(a_out_from_done, clk_i, rst_ni, !$rose(out_valid_o) || ($past(state_q) == S_DONE))

endmodule
